// ===== rtl/sqrt_hsv_colormap_unit_assert.svh =====
// Assertion macros for the colormap RTL.
`ifndef SQRT_HSV_COLORMAP_UNIT_ASSERT_SVH
`define SQRT_HSV_COLORMAP_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SHVC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("colormap assertion failed");

// Next-cycle implication, checked out of reset.
`define SHVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colormap assertion failed");

`endif

// ===== rtl/shvc_pkg.sv =====
package shvc_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  localparam int unsigned HUE_SPAN   = 270;
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned CHAN_MAX   = 255;

  localparam longint unsigned RANGE_LOW_RESET  = 0;
  localparam longint unsigned RANGE_HIGH_RESET = 65535;

  // register indexes of the configuration port
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  // hue sectors of sixty degrees
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED  = 3'd5;

  // normalization outcome that bypasses the divider result
  typedef struct packed {
    logic force_zero;
    logic force_one;
  } norm_flags_t;

endpackage

// ===== rtl/sqrt_hsv_colormap_unit.sv =====
// False-color mapper: one signed sample in, one RGB color out.
// Input channel: in_valid / in_stall with in_sample; a beat moves when
// in_valid is high and in_stall is low. Output channel: out_valid /
// out_stall with out_red, out_green, out_blue, same rule.
// Configuration: cfg_wr_en, cfg_index, cfg_data write range_low (index 0)
// or range_high (index 1); write only while no beat is in flight.
// Throughput: one beat per cycle unless out_stall holds a full output
// register. The pipeline is a row of cells: one normalize stage,
// FRAC_BITS divider cells (one quotient bit each), FRAC_BITS+1
// square-root cells (one root bit each) and five HSV stages, the last
// being the output register.
// Stall: the whole row advances together; when out_stall holds a full
// output register, every stage holds and in_stall rises in the same cycle.
// Reset (synchronous, rst_n low): all stage valid bits clear, range_low
// returns to 0 and range_high to 65535 (truncated to the sample width).
module sqrt_hsv_colormap_unit import shvc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [SAMPLE_WIDTH-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue
);

  `include "sqrt_hsv_colormap_unit_assert.svh"

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned XW = 2 * F + 2;
  localparam int unsigned RW = F + 3;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // the whole row moves when the output register is free or being drained
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // range registers
  logic [W-1:0] range_low_r, range_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= W'(RANGE_LOW_RESET);
      range_high_r <= W'(RANGE_HIGH_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // normalize stage: pick the clamp case, or hand offset and span to the divider
  logic        asc;
  norm_flags_t flags_nxt;
  logic [W-1:0] d_nxt, span_nxt;

  always_comb begin
    asc       = $signed(range_low_r) < $signed(range_high_r);
    flags_nxt = '0;
    if (range_low_r == range_high_r) begin
      flags_nxt.force_zero = 1'b1;
    end else if (asc) begin
      flags_nxt.force_zero = !($signed(range_low_r) < $signed(in_sample));
      flags_nxt.force_one  = !($signed(in_sample) < $signed(range_high_r));
    end else begin
      flags_nxt.force_zero = !($signed(in_sample) < $signed(range_low_r));
      flags_nxt.force_one  = !($signed(range_high_r) < $signed(in_sample));
    end
    d_nxt    = asc ? (in_sample - range_low_r) : (range_low_r - in_sample);
    span_nxt = asc ? (range_high_r - range_low_r) : (range_low_r - range_high_r);
  end

  logic        fr_vld_r;
  norm_flags_t fr_flags_r;
  logic [W-1:0] fr_d_r, fr_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (adv) begin
      fr_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr_flags_r <= flags_nxt;
      fr_d_r     <= d_nxt;
      fr_span_r  <= span_nxt;
    end
  end

  // divider row: one quotient bit per cell
  logic        dv_vld   [F+1];
  norm_flags_t dv_flags [F+1];
  logic [W-1:0] dv_rem  [F+1];
  logic [W-1:0] dv_span [F+1];
  logic [F-1:0] dv_quo  [F+1];

  assign dv_vld[0]   = fr_vld_r;
  assign dv_flags[0] = fr_flags_r;
  assign dv_rem[0]   = fr_d_r;
  assign dv_span[0]  = fr_span_r;
  assign dv_quo[0]   = '0;

  for (genvar i = 0; i < F; i++) begin : g_div
    shvc_div_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (dv_vld[i]),
      .in_flags (dv_flags[i]),
      .in_rem   (dv_rem[i]),
      .in_span  (dv_span[i]),
      .in_quo   (dv_quo[i]),
      .out_vld  (dv_vld[i+1]),
      .out_flags(dv_flags[i+1]),
      .out_rem  (dv_rem[i+1]),
      .out_span (dv_span[i+1]),
      .out_quo  (dv_quo[i+1])
    );
  end

  // normalized value, 0..ONE
  logic [F:0] norm;
  always_comb begin
    if (dv_flags[F].force_zero) begin
      norm = '0;
    end else if (dv_flags[F].force_one) begin
      norm = ONE;
    end else begin
      norm = {1'b0, dv_quo[F]};
    end
  end

  // square-root row over norm * 2^F: one root bit per cell
  logic          sq_vld  [F+2];
  logic [XW-1:0] sq_rad  [F+2];
  logic [RW-1:0] sq_rem  [F+2];
  logic [F:0]    sq_root [F+2];

  assign sq_vld[0]  = dv_vld[F];
  assign sq_rad[0]  = {1'b0, norm, {F{1'b0}}};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    shvc_sqrt_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (sq_vld[j]),
      .in_rad  (sq_rad[j]),
      .in_rem  (sq_rem[j]),
      .in_root (sq_root[j]),
      .out_vld (sq_vld[j+1]),
      .out_rad (sq_rad[j+1]),
      .out_rem (sq_rem[j+1]),
      .out_root(sq_root[j+1])
    );
  end

  // hue, sector and channel stages, ending in the output register
  shvc_hsv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_hsv (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sq_vld[F+1]),
    .in_sat   (sq_root[F+1]),
    .out_vld  (out_valid),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
  );

  // hold input only behind a stalled, full output register
  `SHVC_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
  // normalized value never exceeds one
  `SHVC_ASSERT_IMPL(a_norm_bound, dv_vld[F], norm <= ONE)
  // saturation never exceeds one
  `SHVC_ASSERT_IMPL(a_sat_bound, sq_vld[F+1], sq_root[F+1] <= ONE)

endmodule

// ===== rtl/shvc_div_cell.sv =====
module shvc_div_cell import shvc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  norm_flags_t             in_flags,
  input  logic [SAMPLE_WIDTH-1:0] in_rem,
  input  logic [SAMPLE_WIDTH-1:0] in_span,
  input  logic [FRAC_BITS-1:0]    in_quo,
  output logic                    out_vld,
  output norm_flags_t             out_flags,
  output logic [SAMPLE_WIDTH-1:0] out_rem,
  output logic [SAMPLE_WIDTH-1:0] out_span,
  output logic [FRAC_BITS-1:0]    out_quo
);

  logic [SAMPLE_WIDTH:0]   twice;
  logic                    ge;
  logic [SAMPLE_WIDTH-1:0] rem_nxt;
  logic [FRAC_BITS-1:0]    quo_nxt;

  logic                    vld_r;
  norm_flags_t             flags_r;
  logic [SAMPLE_WIDTH-1:0] rem_r;
  logic [SAMPLE_WIDTH-1:0] span_r;
  logic [FRAC_BITS-1:0]    quo_r;

  // one restoring step: double, try the divisor, keep one quotient bit
  always_comb begin
    twice   = {in_rem, 1'b0};
    ge      = twice >= {1'b0, in_span};
    rem_nxt = ge ? SAMPLE_WIDTH'(twice - {1'b0, in_span}) : SAMPLE_WIDTH'(twice);
    quo_nxt = {in_quo[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_r <= in_flags;
      rem_r   <= rem_nxt;
      span_r  <= in_span;
      quo_r   <= quo_nxt;
    end
  end

  assign out_vld   = vld_r;
  assign out_flags = flags_r;
  assign out_rem   = rem_r;
  assign out_span  = span_r;
  assign out_quo   = quo_r;

endmodule

// ===== rtl/shvc_sqrt_cell.sv =====
module shvc_sqrt_cell import shvc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [2*FRAC_BITS+1:0] in_rad,
  input  logic [FRAC_BITS+2:0]   in_rem,
  input  logic [FRAC_BITS:0]     in_root,
  output logic                   out_vld,
  output logic [2*FRAC_BITS+1:0] out_rad,
  output logic [FRAC_BITS+2:0]   out_rem,
  output logic [FRAC_BITS:0]     out_root
);

  localparam int unsigned RW = FRAC_BITS + 3;
  localparam int unsigned XW = 2 * FRAC_BITS + 2;

  logic [RW-1:0]        rem_s;
  logic [RW-1:0]        trial;
  logic                 ge;
  logic [RW-1:0]        rem_nxt;
  logic [FRAC_BITS:0]   root_nxt;
  logic [XW-1:0]        rad_nxt;

  logic                 vld_r;
  logic [XW-1:0]        rad_r;
  logic [RW-1:0]        rem_r;
  logic [FRAC_BITS:0]   root_r;

  // one root bit: bring down two radicand bits, test root*4+1
  always_comb begin
    rem_s    = {in_rem[RW-3:0], in_rad[XW-1:XW-2]};
    trial    = {in_root, 2'b01};
    ge       = rem_s >= trial;
    rem_nxt  = ge ? (rem_s - trial) : rem_s;
    root_nxt = {in_root[FRAC_BITS-1:0], ge};
    rad_nxt  = {in_rad[XW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;

endmodule

// ===== rtl/shvc_hsv.sv =====
module shvc_hsv import shvc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [FRAC_BITS:0] in_sat,
  output logic               out_vld,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int unsigned F  = FRAC_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [F-1:0] ftab [64];

  for (genvar g = 0; g < 64; g++) begin : g_ftab
    if (g < SECTOR_DEG) begin : g_used
      assign ftab[g] = F'((64'(g) << FRAC_BITS) / SECTOR_DEG);
    end else begin : g_unused
      assign ftab[g] = '0;
    end
  end

  logic [4:0]     vld_r;
  logic [F+9:0]   prod1_r;
  logic [F:0]     s1_r;
  logic [F:0]     s2_r;
  logic [2:0]     sec2_r;
  logic [F-1:0]   f2_r;
  logic [2*F:0]   sf3_r;
  logic [2*F+1:0] st3_r;
  logic [F:0]     p3_r;
  logic [2:0]     sec3_r;
  logic [F:0]     p4_r, q4_r, t4_r;
  logic [2:0]     sec4_r;
  logic [7:0]     red_r, green_r, blue_r;

  logic [8:0]     hue;
  logic [2:0]     sec_nxt;
  logic [8:0]     base;
  logic [5:0]     deg;
  logic [F:0]     q_nxt, t_nxt;
  logic [7:0]     pc, qc, tc;
  logic [7:0]     red_nxt, green_nxt, blue_nxt;

  function automatic logic [7:0] to_chan(input logic [FRAC_BITS:0] x);
    logic [FRAC_BITS+8:0] prod;
    prod    = (FRAC_BITS+9)'(x) * (FRAC_BITS+9)'(CHAN_MAX);
    to_chan = prod[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // hue and its sector
  always_comb begin
    hue = 9'(10'(HUE_SPAN) - prod1_r[F+9:F]);
    if (hue >= 9'(5 * SECTOR_DEG)) begin
      sec_nxt = SEC_MAG_RED;
      base    = 9'(5 * SECTOR_DEG);
    end else if (hue >= 9'(4 * SECTOR_DEG)) begin
      sec_nxt = SEC_BLU_MAG;
      base    = 9'(4 * SECTOR_DEG);
    end else if (hue >= 9'(3 * SECTOR_DEG)) begin
      sec_nxt = SEC_CYN_BLU;
      base    = 9'(3 * SECTOR_DEG);
    end else if (hue >= 9'(2 * SECTOR_DEG)) begin
      sec_nxt = SEC_GRN_CYN;
      base    = 9'(2 * SECTOR_DEG);
    end else if (hue >= 9'(SECTOR_DEG)) begin
      sec_nxt = SEC_YEL_GRN;
      base    = 9'(SECTOR_DEG);
    end else begin
      sec_nxt = SEC_RED_YEL;
      base    = '0;
    end
    deg = 6'(hue - base);
  end

  always_comb begin
    q_nxt = ONE - sf3_r[2*F:F];
    t_nxt = (F+1)'({1'b0, ONE} - st3_r[2*F+1:F]);
  end

  always_comb begin
    pc = to_chan(p4_r);
    qc = to_chan(q4_r);
    tc = to_chan(t4_r);
    case (sec4_r)
      SEC_YEL_GRN: begin red_nxt = qc; green_nxt = 8'(CHAN_MAX); blue_nxt = pc; end
      SEC_GRN_CYN: begin red_nxt = pc; green_nxt = 8'(CHAN_MAX); blue_nxt = tc; end
      SEC_CYN_BLU: begin red_nxt = pc; green_nxt = qc; blue_nxt = 8'(CHAN_MAX); end
      SEC_BLU_MAG: begin red_nxt = tc; green_nxt = pc; blue_nxt = 8'(CHAN_MAX); end
      SEC_MAG_RED: begin red_nxt = 8'(CHAN_MAX); green_nxt = pc; blue_nxt = qc; end
      default:     begin red_nxt = 8'(CHAN_MAX); green_nxt = tc; blue_nxt = pc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= (F+10)'(in_sat) * (F+10)'(HUE_SPAN) + (F+10)'(ONE - 1'b1);
      s1_r    <= in_sat;
      s2_r    <= s1_r;
      sec2_r  <= sec_nxt;
      f2_r    <= ftab[deg];
      sf3_r   <= (2*F+1)'(s2_r) * (2*F+1)'(f2_r);
      st3_r   <= (2*F+2)'(s2_r) * (2*F+2)'(ONE - {1'b0, f2_r});
      p3_r    <= ONE - s2_r;
      sec3_r  <= sec2_r;
      p4_r    <= p3_r;
      q4_r    <= q_nxt;
      t4_r    <= t_nxt;
      sec4_r  <= sec3_r;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_vld   = vld_r[4];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ===== verif/tb.sv =====
module tb;
  import shvc_pkg::*;

  localparam int unsigned SW = 32;
  localparam int unsigned FB = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FB;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = REG_RANGE_LOW;
  logic [SW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SW-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;

  // local copy of the range registers, updated with every write
  logic signed [SW-1:0] bound_low = 0;
  logic signed [SW-1:0] bound_high = 65535;

  logic [SW-1:0] sample_queue[$];
  color_t color_queue[$];
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit calm = 1'b0;

  sqrt_hsv_colormap_unit dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Normalize against the bounds, take the root, then run HSV to RGB.
  function automatic color_t map_color(logic signed [SW-1:0] v,
                                       logic signed [SW-1:0] lo,
                                       logic signed [SW-1:0] hi);
    longint unsigned n, s, hue, f, p, q, t, pc, qc, tc;
    logic [2:0] sector;
    color_t c;
    if (lo == hi) n = 0;
    else if (lo < hi) begin
      if (v <= lo) n = 0;
      else if (v >= hi) n = ONE_Q;
      else n = ((longint'(v) - longint'(lo)) << FB) / (longint'(hi) - longint'(lo));
    end else begin
      if (v >= lo) n = 0;
      else if (v <= hi) n = ONE_Q;
      else n = ((longint'(lo) - longint'(v)) << FB) / (longint'(lo) - longint'(hi));
    end
    s = int_sqrt(n << FB);
    if (s > ONE_Q) s = ONE_Q;
    hue = HUE_SPAN - ((HUE_SPAN * s + ONE_Q - 1) >> FB);
    sector = 3'(hue / SECTOR_DEG);
    f = ((hue % SECTOR_DEG) << FB) / SECTOR_DEG;
    p = ONE_Q - s;
    q = ONE_Q - ((s * f) >> FB);
    t = ONE_Q - ((s * (ONE_Q - f)) >> FB);
    pc = ((p * CHAN_MAX) >> FB) & 8'hFF;
    qc = ((q * CHAN_MAX) >> FB) & 8'hFF;
    tc = ((t * CHAN_MAX) >> FB) & 8'hFF;
    case (sector)
      SEC_YEL_GRN: c = '{8'(qc), 8'(CHAN_MAX), 8'(pc)};
      SEC_GRN_CYN: c = '{8'(pc), 8'(CHAN_MAX), 8'(tc)};
      SEC_CYN_BLU: c = '{8'(pc), 8'(qc), 8'(CHAN_MAX)};
      SEC_BLU_MAG: c = '{8'(tc), 8'(pc), 8'(CHAN_MAX)};
      SEC_MAG_RED: c = '{8'(CHAN_MAX), 8'(pc), 8'(qc)};
      default:     c = '{8'(CHAN_MAX), 8'(tc), 8'(pc)};
    endcase
    return c;
  endfunction

  // Mostly short gaps, a few long ones; none while calm.
  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Driver: predict each accepted beat, then hold or advance the payload.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        color_queue.push_back(map_color(in_sample, bound_low, bound_high));
        beats_in <= beats_in + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_sample <= sample_queue.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check the oldest expected color, then pick the next stall.
  always @(posedge clk) begin
    color_t exp_c;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (color_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected beat r=%0d g=%0d b=%0d", $time,
                   out_red, out_green, out_blue);
        end else begin
          exp_c = color_queue.pop_front();
          if (exp_c.red !== out_red || exp_c.green !== out_green ||
              exp_c.blue !== out_blue) begin
            mismatches <= mismatches + 1;
            $display("%0t: color mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                     $time, exp_c.red, exp_c.green, exp_c.blue,
                     out_red, out_green, out_blue);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        recv_gap <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sqrt_hsv_colormap_unit regression: fail");
      $finish;
    end
  end

  // Let the pipe drain; every beat yields a color, so an empty queue means idle.
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || color_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bounds(logic signed [SW-1:0] lo, logic signed [SW-1:0] hi);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_RANGE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_RANGE_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bound_low = lo;
    bound_high = hi;
  endtask

  // Random samples: mostly inside the range, some near the bounds, some anywhere.
  task automatic queue_random(int unsigned count);
    longint lo, hi, span, v;
    int unsigned r;
    lo = (bound_low < bound_high) ? bound_low : bound_high;
    hi = (bound_low < bound_high) ? bound_high : bound_low;
    span = hi - lo;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 60) v = lo + longint'({$urandom, $urandom} % (span + 1));
      else if (r < 80) v = ($urandom_range(1) ? lo : hi) + $signed($urandom_range(6)) - 3;
      else v = $signed($urandom);
      sample_queue.push_back(SW'(v));
    end
  endtask

  initial begin
    logic signed [SW-1:0] lows[$], highs[$];
    lows  = '{0, 32'sh8000_0000, 32'sh7fff_ffff, 5, -100, 1000, 0, 32'sh8000_0000,
              -1, 7};
    highs = '{65535, 32'sh7fff_ffff, 32'sh8000_0000, 5, 100, -1000, 1, 32'sh8000_0001,
              0, 6};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at reset bounds: extremes, bounds, their neighbors, the five sectors that hue reaches.
    sample_queue = '{32'h8000_0000, 32'h7fff_ffff, 0, 1, 65535, 65534, 65536,
                     32'hffff_ffff, 32'h0000_8000, 16384, 4096, 1024, 256, 49152,
                     36000, 12000, 20000, 60000, 64, 16};
    drain();

    for (int i = 0; i < lows.size() + 4; i++) begin
      if (i < lows.size()) write_bounds(lows[i], highs[i]);
      else write_bounds($signed($urandom), $signed($urandom));
      calm = (i % 4 == 3);
      // the bounds themselves and the full-scale extremes for every setting
      sample_queue.push_back(bound_low);
      sample_queue.push_back(bound_high);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h7fff_ffff);
      queue_random(125);
      drain();
    end

    $display("covered %0d beats in, %0d colors out over %0d bound settings",
             beats_in, beats_out, lows.size() + 5);
    $display("settings included equal, reversed, full-scale and random bounds");
    if (mismatches == 0 && color_queue.size() == 0)
      $display("sqrt_hsv_colormap_unit regression: pass");
    else
      $display("sqrt_hsv_colormap_unit regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/shvc_pkg.sv
rtl/shvc_div_cell.sv
rtl/shvc_sqrt_cell.sv
rtl/shvc_hsv.sv
rtl/sqrt_hsv_colormap_unit.sv
verif/tb.sv
